@@ sv/tfnc_pkg.sv @@
// ----------------------------------------------------------------------------
// tfnc_pkg
// Shared widths and constants for the triangle face normal and centroid unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tfnc_pkg;

  // Field widths.
  localparam int unsigned POS_W = 24;
  localparam int unsigned NRM_W = 16;
  localparam int unsigned SUM_W = 17;

  // Width of the shared signed multiplier operands.
  localparam int unsigned MUL_W = 31;

  // Divide by three: multiply by ceil(2^26 / 3), then shift right by 26.
  localparam int unsigned RECIP3_SHIFT = 26;
  localparam logic [30:0] RECIP3 = 31'(((64'd1 << RECIP3_SHIFT) + 64'd2) / 64'd3);

  // Q2.14 unit length and the bound of the normalized cross magnitudes.
  localparam int unsigned UNIT_SHIFT = 14;
  localparam int unsigned NORM_LIMIT = 30;

  // Restoring square root: 31 result bits, first test bit 2^60.
  localparam int unsigned ROOT_STEPS = 31;
  // Division: 15 quotient bits, since a quotient never passes 16384.
  localparam int unsigned DIV_STEPS = 15;

endpackage

`default_nettype wire

@@ sv/triangle_face_normal_centroid_unit.sv @@
// ----------------------------------------------------------------------------
// triangle_face_normal_centroid_unit
// Takes triangle vertices in face order and gives the centroid and the
// oriented unit face normal of each triangle.
// ----------------------------------------------------------------------------
// The first and second vertex of a face are stored and leave the block
// ready at once. The third vertex starts a sequencer around one shared
// 31 x 31 signed multiplier, a restoring square root and a restoring divider,
// which steps through centroid, cross product, magnitude and normalizing
// shift, squares, square root, division, dot product and orientation fix.
// A zero-area face goes from the shift straight to the output. The result is
// loaded into the output register once that register is free or being taken,
// and the block is ready again on the next cycle. The output register holds a
// result while the next face's first vertices are already transferred.
`default_nettype none

module triangle_face_normal_centroid_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic signed [15:0] nrm_x,
  input  logic signed [15:0] nrm_y,
  input  logic signed [15:0] nrm_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] center_x,
  output logic signed [23:0] center_y,
  output logic signed [23:0] center_z,
  output logic signed [15:0] face_x,
  output logic signed [15:0] face_y,
  output logic signed [15:0] face_z,
  output logic               degenerate
);

  typedef enum logic [3:0] {
    S_IDLE, S_CTR, S_CROSS, S_SHIFT, S_SQ, S_ROOT, S_DLOAD, S_DSTEP, S_DOT,
    S_FIX, S_OUT
  } state_t;

  state_t state;
  logic [1:0] slot;
  logic [4:0] idx;
  logic [1:0] comp;
  logic       ph;

  logic signed [23:0] hp   [0:5];
  logic signed [16:0] ns   [0:2];
  logic signed [24:0] e1   [0:2];
  logic signed [24:0] e2   [0:2];
  logic signed [25:0] csum [0:2];
  logic signed [23:0] ctr  [0:2];
  logic signed [50:0] cr   [0:2];
  logic        [50:0] mag  [0:2];
  logic signed [15:0] face [0:2];
  logic        [61:0] sq;
  logic        [61:0] rbit;
  logic        [61:0] res;
  logic        [30:0] len;
  logic        [30:0] rem;
  logic        [14:0] numlo;
  logic        [14:0] qt;
  logic signed [35:0] dot;
  logic signed [61:0] prod;
  logic               degen;

  logic signed [tfnc_pkg::MUL_W-1:0] mul_a;
  logic signed [tfnc_pkg::MUL_W-1:0] mul_b;
  logic signed [61:0]                mul_p;

  logic signed [23:0] p_in [0:2];
  logic signed [15:0] n_in [0:2];
  logic               take;

  // Shared-unit scratch values.
  logic [25:0] cabs;
  logic        big;
  logic [61:0] rtry;
  logic [61:0] res_next;
  logic [44:0] num;
  logic [31:0] rem2;
  logic [1:0]  k2;

  assign p_in[0] = pos_x;
  assign p_in[1] = pos_y;
  assign p_in[2] = pos_z;
  assign n_in[0] = nrm_x;
  assign n_in[1] = nrm_y;
  assign n_in[2] = nrm_z;

  assign in_ready = (state == S_IDLE);
  assign take     = in_valid && in_ready;

  // Operand selection for the shared multiplier.
  always_comb begin
    cabs  = csum[comp][25] ? 26'(-csum[comp]) : 26'(csum[comp]);
    mul_a = '0;
    mul_b = '0;
    k2    = idx[2:1];
    case (state)
      S_CTR: begin
        mul_a = $signed({5'b0, cabs});
        mul_b = $signed(tfnc_pkg::RECIP3);
      end
      S_CROSS: begin
        case (idx[2:0])
          3'd0: begin mul_a = 31'(e1[1]); mul_b = 31'(e2[2]); end
          3'd1: begin mul_a = 31'(e1[2]); mul_b = 31'(e2[1]); end
          3'd2: begin mul_a = 31'(e1[2]); mul_b = 31'(e2[0]); end
          3'd3: begin mul_a = 31'(e1[0]); mul_b = 31'(e2[2]); end
          3'd4: begin mul_a = 31'(e1[0]); mul_b = 31'(e2[1]); end
          3'd5: begin mul_a = 31'(e1[1]); mul_b = 31'(e2[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_SQ: begin
        mul_a = $signed({1'b0, mag[comp][29:0]});
        mul_b = $signed({1'b0, mag[comp][29:0]});
      end
      S_DOT: begin
        mul_a = 31'(face[comp]);
        mul_b = 31'(ns[comp]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = 62'(mul_a * mul_b);
    big   = (mag[0][50:tfnc_pkg::NORM_LIMIT] != '0) ||
            (mag[1][50:tfnc_pkg::NORM_LIMIT] != '0) ||
            (mag[2][50:tfnc_pkg::NORM_LIMIT] != '0);
    rtry     = res + rbit;
    res_next = (sq >= rtry) ? ((res >> 1) + rbit) : (res >> 1);
    num   = {1'b0, mag[comp][29:0], 14'b0} + {15'b0, len[30:1]};
    rem2  = {rem, numlo[14]};
  end

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slot      <= '0;
      idx       <= '0;
      comp      <= '0;
      ph        <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) ns[i] <= '0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take) begin
            for (int i = 0; i < 3; i++) begin
              if (slot == 2'd0) begin
                ns[i] <= 17'(n_in[i]);
              end else begin
                ns[i] <= ns[i] + 17'(n_in[i]);
              end
            end
            if (slot == 2'd0 || slot == 2'd1) begin
              for (int i = 0; i < 3; i++) begin
                if (slot[0]) hp[3+i] <= p_in[i];
                else         hp[i]   <= p_in[i];
              end
              slot <= slot + 2'd1;
            end else begin
              for (int i = 0; i < 3; i++) begin
                csum[i] <= 26'(hp[i]) + 26'(hp[3+i]) + 26'(p_in[i]);
                e1[i]   <= 25'(hp[3+i]) - 25'(hp[i]);
                e2[i]   <= 25'(p_in[i]) - 25'(hp[i]);
              end
              slot  <= '0;
              comp  <= '0;
              idx   <= '0;
              ph    <= 1'b0;
              state <= S_CTR;
            end
          end
        end
        // Centroid: magnitude times the reciprocal of three, sign restored.
        S_CTR: begin
          ph <= ~ph;
          if (!ph) begin
            prod <= mul_p;
          end else begin
            ctr[comp] <= csum[comp][25] ? -$signed(prod[49:26]) : $signed(prod[49:26]);
            if (comp == 2'd2) begin
              state <= S_CROSS;
              idx   <= '0;
            end
            comp <= comp + 2'd1;
          end
        end
        // Cross product: six products, each pair forming one component.
        S_CROSS: begin
          if (!ph) begin
            ph   <= 1'b1;
            prod <= mul_p;
          end else begin
            if (!idx[0]) cr[k2] <= 51'(prod);
            else         cr[k2] <= cr[k2] - 51'(prod);
            // The phase stays high into the shift stage.
            if (idx == 5'd5) state <= S_SHIFT;
            else             ph    <= 1'b0;
            idx <= idx + 5'd1;
          end
        end
        // Take magnitudes, then shift all right until each is below 2^30.
        S_SHIFT: begin
          if (ph) begin
            ph    <= 1'b0;
            degen <= (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
            for (int i = 0; i < 3; i++) begin
              mag[i]  <= cr[i][50] ? 51'(-cr[i]) : 51'(cr[i]);
              face[i] <= '0;
            end
          end else if (degen) begin
            state <= S_OUT;
          end else if (big) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else begin
            state <= S_SQ;
            comp  <= '0;
            sq    <= '0;
          end
        end
        // Sum of squares.
        S_SQ: begin
          ph <= ~ph;
          if (!ph) begin
            prod <= mul_p;
          end else begin
            sq <= sq + 62'(prod);
            if (comp == 2'd2) begin
              state <= S_ROOT;
              idx   <= '0;
              res   <= '0;
              rbit  <= 62'd1 << 60;
            end
            comp <= comp + 2'd1;
          end
        end
        // Restoring integer square root, one result bit a cycle.
        S_ROOT: begin
          if (sq >= rtry) sq <= sq - rtry;
          res  <= res_next;
          rbit <= rbit >> 2;
          idx  <= idx + 5'd1;
          if (idx == 5'(tfnc_pkg::ROOT_STEPS - 1)) begin
            // Latch the length; a zero root is taken as one.
            len   <= (res_next[30:0] == '0) ? 31'd1 : res_next[30:0];
            state <= S_DLOAD;
            comp  <= '0;
          end
        end
        // Load the rounded numerator of one component.
        S_DLOAD: begin
          rem   <= 31'(num[44:15]);
          numlo <= num[14:0];
          qt    <= '0;
          idx   <= '0;
          state <= S_DSTEP;
        end
        // Restoring division, one quotient bit a cycle.
        S_DSTEP: begin
          if (rem2 >= {1'b0, len}) begin
            rem <= 31'(rem2 - {1'b0, len});
            qt  <= {qt[13:0], 1'b1};
          end else begin
            rem <= rem2[30:0];
            qt  <= {qt[13:0], 1'b0};
          end
          numlo <= numlo << 1;
          idx   <= idx + 5'd1;
          if (idx == 5'(tfnc_pkg::DIV_STEPS)) begin
            face[comp] <= cr[comp][50] ? -$signed({1'b0, qt}) : $signed({1'b0, qt});
            if (comp == 2'd2) begin
              state <= S_DOT;
              comp  <= '0;
              dot   <= '0;
              ph    <= 1'b0;
            end else begin
              comp  <= comp + 2'd1;
              state <= S_DLOAD;
            end
          end
        end
        // Orientation test against the summed vertex normals.
        S_DOT: begin
          ph <= ~ph;
          if (!ph) begin
            prod <= mul_p;
          end else begin
            dot <= dot + 36'(prod);
            if (comp == 2'd2) state <= S_FIX;
            comp <= comp + 2'd1;
          end
        end
        S_FIX: begin
          if (dot[35]) begin
            for (int i = 0; i < 3; i++) face[i] <= -face[i];
          end
          state <= S_OUT;
        end
        // Load the output register once it is free.
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            center_x   <= ctr[0];
            center_y   <= ctr[1];
            center_z   <= ctr[2];
            face_x     <= face[0];
            face_y     <= face[1];
            face_z     <= face[2];
            degenerate <= degen;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A zero-area face reports a zero normal.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> face_x == 0 && face_y == 0 && face_z == 0)
    else $error("degenerate result with nonzero normal");

  // The face slot never reaches its unused code.
  a_slot_range: assert property (@(posedge clk) disable iff (rst) slot != 2'd3)
    else $error("vertex slot out of range");

  // A third vertex starts the sequencer, which holds off further transfers.
  a_third_busy: assert property (@(posedge clk) disable iff (rst)
    take && slot == 2'd2 |=> !in_ready)
    else $error("block ready right after a third vertex");

  // Normal components stay within the Q2.14 unit range.
  a_face_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> face_x <= 16384 && face_x >= -16384 &&
                  face_y <= 16384 && face_y >= -16384 &&
                  face_z <= 16384 && face_z >= -16384)
    else $error("face normal component out of range");

endmodule

`default_nettype wire
